// ===== design/ps2kd_pkg.sv =====
// Shared types, codes and scan code tables for the PS/2 set-2 key decoder.
package ps2kd_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 3;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Scan code prefixes.
  localparam logic [7:0] SC_EXT   = 8'he0;
  localparam logic [7:0] SC_BREAK = 8'hf0;

  // Request codes on the input channel.
  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_RD_CHAR = 2'd1,
    MODE_RD_SPEC = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  // Kind of a queued key.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_SPEC = 2'd2
  } kind_t;

  // Prefix tracking states.
  typedef enum logic [1:0] {
    PFX_IDLE  = 2'd0,
    PFX_EXT   = 2'd1,
    PFX_BREAK = 2'd2
  } pfx_state_t;

  // Special key codes.
  localparam logic [7:0] SPK_BKSP  = 8'd1;
  localparam logic [7:0] SPK_TAB   = 8'd2;
  localparam logic [7:0] SPK_CAPS  = 8'd3;
  localparam logic [7:0] SPK_ENTER = 8'd4;
  localparam logic [7:0] SPK_ESC   = 8'd5;
  localparam logic [7:0] SPK_DEL   = 8'd6;
  localparam logic [7:0] SPK_UP    = 8'd7;
  localparam logic [7:0] SPK_DOWN  = 8'd8;
  localparam logic [7:0] SPK_LEFT  = 8'd9;
  localparam logic [7:0] SPK_RIGHT = 8'd10;
  localparam logic [7:0] SPK_F1    = 8'd11;

  // One decoded key.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
  } key_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_ext;
    logic is_break;
    logic plain_hit;
    logic ext_hit;
    logic head_char;
    logic head_spec;
  } dp_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
    logic use_ext;
    logic pop;
  } dp_cmd_t;

  function automatic key_t ch(input logic [7:0] c);
    key_t k;
    k.kind = KIND_CHAR;
    k.code = c;
    return k;
  endfunction

  function automatic key_t sp(input logic [7:0] c);
    key_t k;
    k.kind = KIND_SPEC;
    k.code = c;
    return k;
  endfunction

  // Plain (unprefixed) make codes.
  function automatic key_t plain_map(input logic [7:0] b);
    key_t k;
    k.kind = KIND_NONE;
    k.code = 8'h00;
    case (b)
      8'h16: k = ch("1");
      8'h1e: k = ch("2");
      8'h26: k = ch("3");
      8'h25: k = ch("4");
      8'h2e: k = ch("5");
      8'h36: k = ch("6");
      8'h3d: k = ch("7");
      8'h3e: k = ch("8");
      8'h46: k = ch("9");
      8'h45: k = ch("0");
      8'h4e: k = ch("-");
      8'h55: k = ch("=");
      8'h66: k = sp(SPK_BKSP);
      8'h0d: k = sp(SPK_TAB);
      8'h15: k = ch("Q");
      8'h1d: k = ch("W");
      8'h24: k = ch("E");
      8'h2d: k = ch("R");
      8'h2c: k = ch("T");
      8'h35: k = ch("Y");
      8'h3c: k = ch("U");
      8'h43: k = ch("I");
      8'h44: k = ch("O");
      8'h4d: k = ch("P");
      8'h54: k = ch("[");
      8'h5b: k = ch("]");
      8'h5d: k = ch(8'h5c);
      8'h58: k = sp(SPK_CAPS);
      8'h1c: k = ch("A");
      8'h1b: k = ch("S");
      8'h23: k = ch("D");
      8'h2b: k = ch("F");
      8'h34: k = ch("G");
      8'h33: k = ch("H");
      8'h3b: k = ch("J");
      8'h42: k = ch("K");
      8'h4b: k = ch("L");
      8'h4c: k = ch(";");
      8'h52: k = ch(8'h27);
      8'h5a: k = sp(SPK_ENTER);
      8'h1a: k = ch("Z");
      8'h22: k = ch("X");
      8'h21: k = ch("C");
      8'h2a: k = ch("V");
      8'h32: k = ch("B");
      8'h31: k = ch("N");
      8'h3a: k = ch("M");
      8'h41: k = ch(",");
      8'h49: k = ch(".");
      8'h4a: k = ch("/");
      8'h29: k = ch(" ");
      8'h76: k = sp(SPK_ESC);
      8'h70: k = ch("0");
      8'h69: k = ch("1");
      8'h72: k = ch("2");
      8'h7a: k = ch("3");
      8'h6b: k = ch("4");
      8'h73: k = ch("5");
      8'h74: k = ch("6");
      8'h6c: k = ch("7");
      8'h75: k = ch("8");
      8'h7d: k = ch("9");
      8'h7b: k = ch("-");
      8'h71: k = ch(".");
      8'h7c: k = ch("*");
      8'h79: k = ch("+");
      8'h05: k = sp(SPK_F1);
      8'h06: k = sp(SPK_F1 + 8'd1);
      8'h04: k = sp(SPK_F1 + 8'd2);
      8'h0c: k = sp(SPK_F1 + 8'd3);
      8'h03: k = sp(SPK_F1 + 8'd4);
      8'h0b: k = sp(SPK_F1 + 8'd5);
      8'h83: k = sp(SPK_F1 + 8'd6);
      8'h0a: k = sp(SPK_F1 + 8'd7);
      8'h01: k = sp(SPK_F1 + 8'd8);
      8'h09: k = sp(SPK_F1 + 8'd9);
      8'h78: k = sp(SPK_F1 + 8'd10);
      8'h07: k = sp(SPK_F1 + 8'd11);
      default: k = k;
    endcase
    return k;
  endfunction

  // Make codes that follow the E0 prefix.
  function automatic key_t ext_map(input logic [7:0] b);
    key_t k;
    k.kind = KIND_NONE;
    k.code = 8'h00;
    case (b)
      8'h71: k = sp(SPK_DEL);
      8'h75: k = sp(SPK_UP);
      8'h72: k = sp(SPK_DOWN);
      8'h6b: k = sp(SPK_LEFT);
      8'h74: k = sp(SPK_RIGHT);
      8'h5a: k = sp(SPK_ENTER);
      8'h4a: k = ch("/");
      default: k = k;
    endcase
    return k;
  endfunction

endpackage

// ===== design/ps2_scan_code_key_decoder_top.sv =====
// Top level of the PS/2 set-2 scan code key decoder with typed key queue.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall   | in_mode, in_scan_byte
//   out_    | output    | out_valid/out_stall | out_got, out_key_code,
//           |           |                     | out_head_kind, out_fill_count
//
// For each item the byte lookup and the queue update settle in
// the cycle of acceptance and the result is registered at that edge.
// One item per cycle is sustained while the result side takes every result.
// The input stalls only while a finished result is held by out_stall.
// Synchronous reset empties the queue and returns the prefix tracker to idle.
module ps2_scan_code_key_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_got,
  output logic [7:0] out_key_code,
  output logic [1:0] out_head_kind,
  output logic [1:0] out_fill_count
);

  ps2kd_pkg::dp_status_t status;
  ps2kd_pkg::dp_cmd_t    cmd;

  // Prefix tracking and handshake control.
  ps2kd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Lookup tables, key queue and result register.
  ps2kd_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_scan_byte   (in_scan_byte),
    .cmd            (cmd),
    .status         (status),
    .out_got        (out_got),
    .out_key_code   (out_key_code),
    .out_head_kind  (out_head_kind),
    .out_fill_count (out_fill_count)
  );

endmodule

// ===== design/ps2kd_ctrl.sv =====
// Controller: prefix state machine, handshake and datapath commands.
module ps2kd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ps2kd_pkg::dp_status_t status,
  output ps2kd_pkg::dp_cmd_t    cmd
);

  ps2kd_pkg::pfx_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept;
  logic                  is_scan;
  logic                  prefix_byte;

  // An item is taken whenever the result register is free or being emptied.
  assign in_stall    = out_valid_r & out_stall;
  assign accept      = in_valid & ~in_stall;
  assign out_valid   = out_valid_r;
  assign is_scan     = (ps2kd_pkg::mode_t'(in_mode) == ps2kd_pkg::MODE_SCAN);
  assign prefix_byte = status.is_ext | status.is_break;

  // Next prefix state.
  always_comb begin
    state_nxt = state_r;
    if (accept && is_scan) begin
      case (state_r)
        ps2kd_pkg::PFX_IDLE, ps2kd_pkg::PFX_EXT: begin
          if (status.is_ext) begin
            state_nxt = ps2kd_pkg::PFX_EXT;
          end else if (status.is_break) begin
            state_nxt = ps2kd_pkg::PFX_BREAK;
          end else begin
            state_nxt = ps2kd_pkg::PFX_IDLE;
          end
        end
        default: state_nxt = ps2kd_pkg::PFX_IDLE;
      endcase
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.load    = accept;
    cmd.use_ext = (state_r == ps2kd_pkg::PFX_EXT);
    case (ps2kd_pkg::mode_t'(in_mode))
      ps2kd_pkg::MODE_SCAN: begin
        case (state_r)
          ps2kd_pkg::PFX_IDLE: cmd.push = accept & ~prefix_byte & status.plain_hit;
          ps2kd_pkg::PFX_EXT:  cmd.push = accept & ~prefix_byte & status.ext_hit;
          default:             cmd.push = 1'b0;
        endcase
      end
      ps2kd_pkg::MODE_RD_CHAR: cmd.pop = accept & status.head_char;
      ps2kd_pkg::MODE_RD_SPEC: cmd.pop = accept & status.head_spec;
      default:                 cmd.pop = 1'b0;
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ps2kd_pkg::PFX_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/ps2kd_datapath.sv =====
// Datapath: scan code lookup, typed key queue and result registers.
module ps2kd_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_scan_byte,
  input  ps2kd_pkg::dp_cmd_t    cmd,
  output ps2kd_pkg::dp_status_t status,
  output logic                  out_got,
  output logic [7:0]            out_key_code,
  output logic [1:0]            out_head_kind,
  output logic [1:0]            out_fill_count
);

  localparam int D = ps2kd_pkg::QUEUE_DEPTH;

  ps2kd_pkg::kind_t           kind_r   [D];
  ps2kd_pkg::kind_t           kind_nxt [D];
  logic [7:0]                 code_r   [D];
  logic [7:0]                 code_nxt [D];
  logic [ps2kd_pkg::CNT_W-1:0] count_r, count_nxt;
  ps2kd_pkg::key_t            plain_key, ext_key, new_key;
  logic                       full;
  logic                       not_empty;
  logic                       got_r;
  logic [7:0]                 key_code_r;
  logic [1:0]                 head_kind_r;
  logic [1:0]                 fill_count_r;

  // Table lookups on the incoming byte.
  assign plain_key = ps2kd_pkg::plain_map(in_scan_byte);
  assign ext_key   = ps2kd_pkg::ext_map(in_scan_byte);
  assign new_key   = cmd.use_ext ? ext_key : plain_key;

  assign full      = (count_r == ps2kd_pkg::CNT_W'(D));
  assign not_empty = (count_r != '0);

  // Status towards the controller.
  always_comb begin
    status           = '0;
    status.is_ext    = (in_scan_byte == ps2kd_pkg::SC_EXT);
    status.is_break  = (in_scan_byte == ps2kd_pkg::SC_BREAK);
    status.plain_hit = (plain_key.kind != ps2kd_pkg::KIND_NONE);
    status.ext_hit   = (ext_key.kind != ps2kd_pkg::KIND_NONE);
    status.head_char = not_empty & (kind_r[0] == ps2kd_pkg::KIND_CHAR);
    status.head_spec = not_empty & (kind_r[0] == ps2kd_pkg::KIND_SPEC);
  end

  // Queue update: append at the first free slot, drop the oldest when full,
  // shift towards the head on a pop.
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < D; i++) begin
      kind_nxt[i] = kind_r[i];
      code_nxt[i] = code_r[i];
    end
    if (cmd.push) begin
      if (full) begin
        for (int i = 0; i < D - 1; i++) begin
          kind_nxt[i] = kind_r[i + 1];
          code_nxt[i] = code_r[i + 1];
        end
        kind_nxt[D - 1] = new_key.kind;
        code_nxt[D - 1] = new_key.code;
      end else begin
        for (int i = 0; i < D; i++) begin
          if (count_r == ps2kd_pkg::CNT_W'(i)) begin
            kind_nxt[i] = new_key.kind;
            code_nxt[i] = new_key.code;
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < D - 1; i++) begin
        kind_nxt[i] = kind_r[i + 1];
        code_nxt[i] = code_r[i + 1];
      end
      kind_nxt[D - 1] = ps2kd_pkg::KIND_NONE;
      code_nxt[D - 1] = 8'h00;
      count_nxt       = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < D; i++) begin
        kind_r[i] <= ps2kd_pkg::KIND_NONE;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < D; i++) begin
        kind_r[i] <= kind_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < D; i++) begin
      code_r[i] <= code_nxt[i];
    end
  end

  // Result register, loaded once for every accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      got_r        <= cmd.pop;
      key_code_r   <= cmd.pop ? code_r[0] : 8'h00;
      head_kind_r  <= (count_nxt != '0) ? kind_nxt[0] : ps2kd_pkg::KIND_NONE;
      fill_count_r <= 2'(count_nxt);
    end
  end

  assign out_got        = got_r;
  assign out_key_code   = key_code_r;
  assign out_head_kind  = head_kind_r;
  assign out_fill_count = fill_count_r;

endmodule

// ===== design/ps2kd_checker.sv =====
// Port-level checks for the key decoder, bound to its top level.
module ps2kd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_got,
  input logic [7:0] out_key_code,
  input logic [1:0] out_head_kind,
  input logic [1:0] out_fill_count
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_got) &&
    $stable(out_key_code) && $stable(out_head_kind) && $stable(out_fill_count))
    else $error("held result changed");

  // Every accepted item yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // A scan byte never pops a key.
  a_scan_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode == ps2kd_pkg::MODE_SCAN |=> !out_got)
    else $error("scan byte reported a popped key");

  // A popped key always carries a nonzero code, and a miss reports zero.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_got == (out_key_code != 8'h00)))
    else $error("key code does not match got flag");

  // An empty queue reports no head kind.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_count == 2'd0 |-> out_head_kind == ps2kd_pkg::KIND_NONE)
    else $error("empty queue shows a head kind");

endmodule

bind ps2_scan_code_key_decoder_top ps2kd_checker u_ps2kd_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the PS/2 set-2 scan code key decoder and its key queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2kd_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 48;
  localparam int HOLD_AT     = 800;

  // One item on the input channel.
  typedef struct {
    mode_t      mode;
    logic [7:0] scan_byte;
  } scan_item_t;

  // One expected decoder result.
  typedef struct {
    logic       got;
    logic [7:0] key_code;
    kind_t      head_kind;
    logic [1:0] fill_count;
  } key_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode = MODE_SCAN;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_got;
  logic [7:0] out_key_code;
  logic [1:0] out_head_kind;
  logic [1:0] out_fill_count;

  scan_item_t  pending_items[$];
  key_result_t expected_keys[$];

  // Shadow of the decoder state.
  pfx_state_t  shadow_pfx;
  kind_t       shadow_kind[QUEUE_DEPTH];
  logic [7:0]  shadow_code[QUEUE_DEPTH];
  int          shadow_fill;

  int cycle_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  int keys_popped = 0;
  int keys_dropped = 0;
  int missed_reads = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  ps2_scan_code_key_decoder_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_got        (out_got),
    .out_key_code   (out_key_code),
    .out_head_kind  (out_head_kind),
    .out_fill_count (out_fill_count)
  );

  // Free-running clock.
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic key_t make_key(input kind_t kind, input logic [7:0] code);
    key_t k;
    k.kind = kind;
    k.code = code;
    return k;
  endfunction

  // Unprefixed make codes; the main block and the keypad share digits and some marks.
  function automatic key_t lookup_plain(input logic [7:0] b);
    case (b)
      8'h45, 8'h70: return make_key(KIND_CHAR, "0");
      8'h16, 8'h69: return make_key(KIND_CHAR, "1");
      8'h1e, 8'h72: return make_key(KIND_CHAR, "2");
      8'h26, 8'h7a: return make_key(KIND_CHAR, "3");
      8'h25, 8'h6b: return make_key(KIND_CHAR, "4");
      8'h2e, 8'h73: return make_key(KIND_CHAR, "5");
      8'h36, 8'h74: return make_key(KIND_CHAR, "6");
      8'h3d, 8'h6c: return make_key(KIND_CHAR, "7");
      8'h3e, 8'h75: return make_key(KIND_CHAR, "8");
      8'h46, 8'h7d: return make_key(KIND_CHAR, "9");
      8'h4e, 8'h7b: return make_key(KIND_CHAR, "-");
      8'h49, 8'h71: return make_key(KIND_CHAR, ".");
      8'h55: return make_key(KIND_CHAR, "=");
      8'h7c: return make_key(KIND_CHAR, "*");
      8'h79: return make_key(KIND_CHAR, "+");
      8'h15: return make_key(KIND_CHAR, "Q");
      8'h1d: return make_key(KIND_CHAR, "W");
      8'h24: return make_key(KIND_CHAR, "E");
      8'h2d: return make_key(KIND_CHAR, "R");
      8'h2c: return make_key(KIND_CHAR, "T");
      8'h35: return make_key(KIND_CHAR, "Y");
      8'h3c: return make_key(KIND_CHAR, "U");
      8'h43: return make_key(KIND_CHAR, "I");
      8'h44: return make_key(KIND_CHAR, "O");
      8'h4d: return make_key(KIND_CHAR, "P");
      8'h54: return make_key(KIND_CHAR, "[");
      8'h5b: return make_key(KIND_CHAR, "]");
      8'h5d: return make_key(KIND_CHAR, 8'h5c);
      8'h1c: return make_key(KIND_CHAR, "A");
      8'h1b: return make_key(KIND_CHAR, "S");
      8'h23: return make_key(KIND_CHAR, "D");
      8'h2b: return make_key(KIND_CHAR, "F");
      8'h34: return make_key(KIND_CHAR, "G");
      8'h33: return make_key(KIND_CHAR, "H");
      8'h3b: return make_key(KIND_CHAR, "J");
      8'h42: return make_key(KIND_CHAR, "K");
      8'h4b: return make_key(KIND_CHAR, "L");
      8'h4c: return make_key(KIND_CHAR, ";");
      8'h52: return make_key(KIND_CHAR, 8'h27);
      8'h1a: return make_key(KIND_CHAR, "Z");
      8'h22: return make_key(KIND_CHAR, "X");
      8'h21: return make_key(KIND_CHAR, "C");
      8'h2a: return make_key(KIND_CHAR, "V");
      8'h32: return make_key(KIND_CHAR, "B");
      8'h31: return make_key(KIND_CHAR, "N");
      8'h3a: return make_key(KIND_CHAR, "M");
      8'h41: return make_key(KIND_CHAR, ",");
      8'h4a: return make_key(KIND_CHAR, "/");
      8'h29: return make_key(KIND_CHAR, " ");
      8'h66: return make_key(KIND_SPEC, SPK_BKSP);
      8'h0d: return make_key(KIND_SPEC, SPK_TAB);
      8'h58: return make_key(KIND_SPEC, SPK_CAPS);
      8'h5a: return make_key(KIND_SPEC, SPK_ENTER);
      8'h76: return make_key(KIND_SPEC, SPK_ESC);
      8'h05: return make_key(KIND_SPEC, SPK_F1);
      8'h06: return make_key(KIND_SPEC, SPK_F1 + 8'd1);
      8'h04: return make_key(KIND_SPEC, SPK_F1 + 8'd2);
      8'h0c: return make_key(KIND_SPEC, SPK_F1 + 8'd3);
      8'h03: return make_key(KIND_SPEC, SPK_F1 + 8'd4);
      8'h0b: return make_key(KIND_SPEC, SPK_F1 + 8'd5);
      8'h83: return make_key(KIND_SPEC, SPK_F1 + 8'd6);
      8'h0a: return make_key(KIND_SPEC, SPK_F1 + 8'd7);
      8'h01: return make_key(KIND_SPEC, SPK_F1 + 8'd8);
      8'h09: return make_key(KIND_SPEC, SPK_F1 + 8'd9);
      8'h78: return make_key(KIND_SPEC, SPK_F1 + 8'd10);
      8'h07: return make_key(KIND_SPEC, SPK_F1 + 8'd11);
      default: return make_key(KIND_NONE, 8'h00);
    endcase
  endfunction

  // Make codes that follow the extended prefix.
  function automatic key_t lookup_extended(input logic [7:0] b);
    case (b)
      8'h71: return make_key(KIND_SPEC, SPK_DEL);
      8'h75: return make_key(KIND_SPEC, SPK_UP);
      8'h72: return make_key(KIND_SPEC, SPK_DOWN);
      8'h6b: return make_key(KIND_SPEC, SPK_LEFT);
      8'h74: return make_key(KIND_SPEC, SPK_RIGHT);
      8'h5a: return make_key(KIND_SPEC, SPK_ENTER);
      8'h4a: return make_key(KIND_CHAR, "/");
      default: return make_key(KIND_NONE, 8'h00);
    endcase
  endfunction

  // Move every held key one place toward the head.
  function automatic void shadow_shift();
    for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
      shadow_kind[i] = shadow_kind[i + 1];
      shadow_code[i] = shadow_code[i + 1];
    end
    shadow_kind[QUEUE_DEPTH - 1] = KIND_NONE;
    shadow_code[QUEUE_DEPTH - 1] = 8'h00;
  endfunction

  // Append a decoded key, dropping the oldest one when the queue is full.
  function automatic void shadow_insert(input key_t k);
    if (k.kind == KIND_NONE) return;
    if (shadow_fill >= QUEUE_DEPTH) begin
      shadow_shift();
      shadow_fill = QUEUE_DEPTH - 1;
      keys_dropped++;
    end
    shadow_kind[shadow_fill] = k.kind;
    shadow_code[shadow_fill] = k.code;
    shadow_fill++;
  endfunction

  // Advance the shadow state by one accepted item and queue the result it must give.
  function automatic void predict_key_result(input mode_t mode, input logic [7:0] b);
    key_result_t res;
    kind_t       want;
    res.got = 1'b0;
    res.key_code = 8'h00;
    if (mode == MODE_SCAN) begin
      if (shadow_pfx == PFX_IDLE || shadow_pfx == PFX_EXT) begin
        if (b == SC_EXT) begin
          shadow_pfx = PFX_EXT;
        end else if (b == SC_BREAK) begin
          shadow_pfx = PFX_BREAK;
        end else begin
          shadow_insert(shadow_pfx == PFX_IDLE ? lookup_plain(b) : lookup_extended(b));
          shadow_pfx = PFX_IDLE;
        end
      end else begin
        // The byte after a break prefix is swallowed.
        shadow_pfx = PFX_IDLE;
      end
    end else if (mode == MODE_RD_CHAR || mode == MODE_RD_SPEC) begin
      want = (mode == MODE_RD_CHAR) ? KIND_CHAR : KIND_SPEC;
      if (shadow_fill > 0 && shadow_kind[0] == want) begin
        res.got = 1'b1;
        res.key_code = shadow_code[0];
        shadow_shift();
        shadow_fill--;
        keys_popped++;
      end else begin
        missed_reads++;
      end
    end
    res.head_kind = (shadow_fill > 0) ? shadow_kind[0] : KIND_NONE;
    res.fill_count = 2'(shadow_fill);
    expected_keys.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    $display("MISMATCH at result %0d: %s expected %0d got %0d",
             results_seen, what, exp_v, act_v);
    error_count++;
  endtask

  function automatic void add_item(input mode_t mode, input logic [7:0] b);
    scan_item_t it;
    it.mode = mode;
    it.scan_byte = b;
    pending_items.push_back(it);
  endfunction

  // Idling is switched off for a stretch in the middle of the run.
  function automatic bit quiet_window();
    return items_sent >= 300 && items_sent < 550;
  endfunction

  // Sender: offers the next item once the current one has been taken.
  always @(posedge clk) begin : drive_items
    scan_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_key_result(mode_t'(in_mode), in_scan_byte);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 6)) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_scan_byte <= nxt.scan_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet_window() && ($urandom_range(0, 99) < 6);
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin : check_results
    key_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_keys.size() == 0) begin
        report_mismatch("result with nothing expected, key_code", -1, out_key_code);
      end else begin
        want = expected_keys.pop_front();
        if (out_got !== want.got)
          report_mismatch("got", want.got, out_got);
        if (out_key_code !== want.key_code)
          report_mismatch("key_code", want.key_code, out_key_code);
        if (out_head_kind !== want.head_kind)
          report_mismatch("head_kind", want.head_kind, out_head_kind);
        if (out_fill_count !== want.fill_count)
          report_mismatch("fill_count", want.fill_count, out_fill_count);
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, expected_keys.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin : main_seq
    int         pick;
    logic [7:0] ext_codes[7];
    ext_codes = '{8'h71, 8'h75, 8'h72, 8'h6b, 8'h74, 8'h5a, 8'h4a};
    shadow_pfx = PFX_IDLE;
    shadow_fill = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      shadow_kind[i] = KIND_NONE;
      shadow_code[i] = 8'h00;
    end

    // Directed: empty reads, idle step, extreme bytes, overflow, wrong-kind read,
    // extended and break prefixes, repeated prefixes.
    add_item(MODE_RD_CHAR, 8'h00);
    add_item(MODE_RD_SPEC, 8'hff);
    add_item(MODE_NOP, 8'hff);
    add_item(MODE_SCAN, 8'h00);
    add_item(MODE_SCAN, 8'hff);
    add_item(MODE_SCAN, 8'h1c);
    add_item(MODE_SCAN, 8'h66);
    add_item(MODE_SCAN, 8'h83);
    add_item(MODE_SCAN, 8'h07);
    add_item(MODE_RD_CHAR, 8'h55);
    add_item(MODE_RD_SPEC, 8'haa);
    add_item(MODE_SCAN, SC_EXT);
    add_item(MODE_SCAN, 8'h75);
    add_item(MODE_SCAN, SC_EXT);
    add_item(MODE_SCAN, SC_EXT);
    add_item(MODE_SCAN, 8'h6b);
    add_item(MODE_SCAN, SC_EXT);
    add_item(MODE_SCAN, 8'h1c);
    add_item(MODE_SCAN, SC_BREAK);
    add_item(MODE_SCAN, 8'h1c);
    add_item(MODE_SCAN, SC_EXT);
    add_item(MODE_SCAN, SC_BREAK);
    add_item(MODE_SCAN, 8'h75);
    add_item(MODE_SCAN, SC_BREAK);
    add_item(MODE_SCAN, SC_BREAK);
    add_item(MODE_SCAN, 8'h5a);

    // Random: mostly well-formed make and break sequences and reads, some noise.
    while (pending_items.size() < RANDOM_ITEMS + 26) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_item(MODE_SCAN, 8'($urandom_range(0, 8'h83)));
      end else if (pick < 40) begin
        add_item(MODE_SCAN, SC_EXT);
        if ($urandom_range(0, 9) == 0) add_item(MODE_SCAN, SC_EXT);
        if ($urandom_range(0, 4) == 0)
          add_item(MODE_SCAN, 8'($urandom));
        else
          add_item(MODE_SCAN, ext_codes[$urandom_range(0, 6)]);
      end else if (pick < 50) begin
        if ($urandom_range(0, 2) == 0) add_item(MODE_SCAN, SC_EXT);
        add_item(MODE_SCAN, SC_BREAK);
        add_item(MODE_SCAN, 8'($urandom));
      end else if (pick < 85) begin
        add_item($urandom_range(0, 1) ? MODE_RD_CHAR : MODE_RD_SPEC, 8'($urandom));
      end else if (pick < 95) begin
        add_item(MODE_SCAN, 8'($urandom));
      end else begin
        add_item(MODE_NOP, 8'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items and checked %0d results in %0d cycles.",
             items_sent, results_seen, cycle_count);
    $display("Keys read %0d, reads refused %0d, oldest keys dropped on overflow %0d.",
             keys_popped, missed_reads, keys_dropped);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ps2kd_pkg.sv
design/ps2kd_ctrl.sv
design/ps2kd_datapath.sv
design/ps2_scan_code_key_decoder_top.sv
design/ps2kd_checker.sv
tb/tb_top.sv
